// File: rtl/snmpve_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snmpve_pkg
// Shared types and constants for the SNMP response value extractor.
// ----------------------------------------------------------------------------
package snmpve_pkg;

    // Width of the byte offset and required-end trackers.
    localparam int OFFSET_WIDTH = 18;

    // Output queue depth. Must stay a power of two so the pointers wrap freely.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

    localparam logic KIND_VALUE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_DEV_ERR   = 2'd1;
    localparam logic [1:0] ST_MALFORMED = 2'd2;

    typedef struct packed {
        logic        kind;
        logic [7:0]  value_byte;
        logic [1:0]  status;
        logic [31:0] device_error;
        logic        end_of_run;
    } result_t;

    // Up to two results per accepted byte: a value byte, then a status item.
    typedef struct packed {
        logic    val_valid;
        result_t val_item;
        logic    st_valid;
        result_t st_item;
    } push_t;

endpackage
`default_nettype wire

// File: rtl/snmpve_parser.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snmpve_parser
// BER element walker: holds the parse state and produces the value bytes and
// the final status of each response.
// ----------------------------------------------------------------------------
module snmpve_parser (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               fire,
    input  wire logic [7:0]         data_byte,
    input  wire logic               last_byte,
    output snmpve_pkg::push_t       push
);
    import snmpve_pkg::*;

    localparam logic [3:0] EL_SEQ0      = 4'd0;
    localparam logic [3:0] EL_VERSION   = 4'd1;
    localparam logic [3:0] EL_COMMUNITY = 4'd2;
    localparam logic [3:0] EL_PDU       = 4'd3;
    localparam logic [3:0] EL_REQID     = 4'd4;
    localparam logic [3:0] EL_ERRSTAT   = 4'd5;
    localparam logic [3:0] EL_ERRIDX    = 4'd6;
    localparam logic [3:0] EL_SEQ1      = 4'd7;
    localparam logic [3:0] EL_SEQ2      = 4'd8;
    localparam logic [3:0] EL_OID       = 4'd9;
    localparam logic [3:0] EL_VALUE     = 4'd10;
    localparam logic [3:0] EL_DONE      = 4'd11;

    localparam logic [2:0] SUB_TAG  = 3'd0;
    localparam logic [2:0] SUB_LEN1 = 3'd1;
    localparam logic [2:0] SUB_LONG = 3'd2;
    localparam logic [2:0] SUB_DATA = 3'd3;

    localparam logic [7:0] TAG_SEQ   = 8'h30;
    localparam logic [7:0] TAG_INT   = 8'h02;
    localparam logic [7:0] TAG_OCTET = 8'h04;
    localparam logic [7:0] TAG_OID   = 8'h06;
    localparam logic [7:0] TAG_PDU   = 8'ha2;
    localparam logic [7:0] LEN_INDEF = 8'h80;
    localparam logic [7:0] LEN_RSVD  = 8'hff;

    localparam logic [OFFSET_WIDTH-1:0] OFF_MAX = '1;

    function automatic logic [7:0] tag_for(input logic [3:0] el);
        logic [7:0] t;
        unique case (el)
            EL_SEQ0, EL_SEQ1, EL_SEQ2:               t = TAG_SEQ;
            EL_VERSION, EL_REQID, EL_ERRSTAT, EL_ERRIDX: t = TAG_INT;
            EL_PDU:                                  t = TAG_PDU;
            EL_OID:                                  t = TAG_OID;
            default:                                 t = TAG_OCTET;
        endcase
        return t;
    endfunction

    function automatic logic is_integer(input logic [3:0] el);
        return (el == EL_VERSION) || (el == EL_REQID) || (el == EL_ERRSTAT) ||
               (el == EL_ERRIDX);
    endfunction

    logic [3:0]              el_reg,     el_next;
    logic [2:0]              sub_reg,    sub_next;
    logic [OFFSET_WIDTH-1:0] offset_reg, offset_next;
    logic [OFFSET_WIDTH-1:0] req_end_reg, req_end_next;
    logic [15:0]             rem_reg,    rem_next;
    logic [15:0]             lacc_reg,   lacc_next;
    logic [31:0]             iacc_reg,   iacc_next;
    logic [31:0]             saved_reg,  saved_next;
    logic                    finished_reg, finished_next;
    logic                    failed_reg,   failed_next;

    // Values after this byte is parsed, before the end-of-response clear.
    logic [3:0]              p_el;
    logic [2:0]              p_sub;
    logic [OFFSET_WIDTH-1:0] p_req_end;
    logic [15:0]             p_rem;
    logic [15:0]             p_lacc;
    logic [31:0]             p_iacc;
    logic [31:0]             p_saved;
    logic                    p_finished;
    logic                    p_failed;

    logic [OFFSET_WIDTH-1:0] off_after;
    logic                    active;
    logic                    in_value;
    logic [15:0]             lacc_shift;
    logic [15:0]             rem_dec;
    logic [31:0]             iacc_shift;
    logic                    do_len;
    logic                    do_next;
    logic [15:0]             dlen;
    logic [OFFSET_WIDTH:0]   need_sum;
    logic [OFFSET_WIDTH-1:0] need;
    logic [1:0]              st_code;

    assign off_after  = (offset_reg == OFF_MAX) ? OFF_MAX : offset_reg + 1'b1;
    assign active     = !failed_reg && !finished_reg && (el_reg < EL_DONE);
    assign in_value   = active && (el_reg == EL_VALUE) && (sub_reg == SUB_DATA);
    assign lacc_shift = {lacc_reg[7:0], data_byte};
    assign rem_dec    = rem_reg - 16'd1;
    assign iacc_shift = {iacc_reg[23:0], data_byte};
    assign need_sum   = {1'b0, off_after} + {{(OFFSET_WIDTH + 1 - 16){1'b0}}, dlen};
    assign need       = (need_sum > {1'b0, OFF_MAX}) ? OFF_MAX : need_sum[OFFSET_WIDTH-1:0];

    always_comb
    begin
        p_el       = el_reg;
        p_sub      = sub_reg;
        p_req_end  = req_end_reg;
        p_rem      = rem_reg;
        p_lacc     = lacc_reg;
        p_iacc     = iacc_reg;
        p_saved    = saved_reg;
        p_finished = finished_reg;
        p_failed   = failed_reg;
        do_len     = 1'b0;
        do_next    = 1'b0;
        dlen       = 16'd0;

        if (active)
        begin
            unique case (sub_reg)
                SUB_TAG:
                begin
                    if (data_byte != tag_for(el_reg))
                        p_failed = 1'b1;
                    else
                        p_sub = SUB_LEN1;
                end
                SUB_LEN1:
                begin
                    if (data_byte == LEN_INDEF || data_byte == LEN_RSVD)
                        p_failed = 1'b1;
                    else if (!data_byte[7])
                    begin
                        do_len = 1'b1;
                        dlen   = {8'h00, data_byte};
                    end
                    else if (data_byte[6:0] > 7'd2)
                        p_failed = 1'b1;
                    else
                    begin
                        p_rem  = {14'd0, data_byte[1:0]};
                        p_lacc = 16'd0;
                        p_sub  = SUB_LONG;
                    end
                end
                SUB_LONG:
                begin
                    p_lacc = lacc_shift;
                    p_rem  = rem_dec;
                    if (rem_dec == 16'd0)
                    begin
                        do_len = 1'b1;
                        dlen   = lacc_shift;
                    end
                end
                SUB_DATA:
                begin
                    p_rem = rem_dec;
                    if (is_integer(el_reg))
                    begin
                        p_iacc = iacc_shift;
                        if (rem_dec == 16'd0)
                        begin
                            if (el_reg == EL_VERSION && iacc_shift != 32'd0)
                                p_failed = 1'b1;
                            else if (el_reg == EL_ERRSTAT && iacc_shift != 32'd0)
                            begin
                                p_saved    = iacc_shift;
                                p_el       = EL_DONE;
                                p_sub      = SUB_TAG;
                                p_finished = 1'b1;
                            end
                            else
                                do_next = 1'b1;
                        end
                    end
                    else if (rem_dec == 16'd0)
                        do_next = 1'b1;
                end
                default:
                    p_failed = 1'b1;
            endcase

            if (do_len)
            begin
                if (need > req_end_reg)
                    p_req_end = need;
                if (is_integer(el_reg))
                begin
                    if (dlen != 16'd1 && dlen != 16'd2 && dlen != 16'd4)
                        p_failed = 1'b1;
                    else
                    begin
                        p_iacc = 32'd0;
                        p_rem  = dlen;
                        p_sub  = SUB_DATA;
                    end
                end
                else if (el_reg == EL_COMMUNITY || el_reg == EL_OID || el_reg == EL_VALUE)
                begin
                    if (dlen == 16'd0)
                        do_next = 1'b1;
                    else
                    begin
                        p_rem = dlen;
                        p_sub = SUB_DATA;
                    end
                end
                else
                    do_next = 1'b1;
            end

            if (do_next)
            begin
                p_sub = SUB_TAG;
                if (el_reg == EL_VALUE)
                begin
                    p_el       = EL_DONE;
                    p_finished = 1'b1;
                end
                else
                    p_el = el_reg + 4'd1;
            end
        end
    end

    // Final status, judged on the state left by the last byte.
    always_comb
    begin
        priority if (p_failed || (p_req_end > off_after) || !p_finished)
            st_code = ST_MALFORMED;
        else if (p_saved != 32'd0)
            st_code = ST_DEV_ERR;
        else
            st_code = ST_OK;
    end

    always_comb
    begin
        if (last_byte)
        begin
            el_next       = EL_SEQ0;
            sub_next      = SUB_TAG;
            offset_next   = '0;
            req_end_next  = '0;
            rem_next      = 16'd0;
            lacc_next     = 16'd0;
            iacc_next     = 32'd0;
            saved_next    = 32'd0;
            finished_next = 1'b0;
            failed_next   = 1'b0;
        end
        else
        begin
            el_next       = p_el;
            sub_next      = p_sub;
            offset_next   = off_after;
            req_end_next  = p_req_end;
            rem_next      = p_rem;
            lacc_next     = p_lacc;
            iacc_next     = p_iacc;
            saved_next    = p_saved;
            finished_next = p_finished;
            failed_next   = p_failed;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            el_reg       <= EL_SEQ0;
            sub_reg      <= SUB_TAG;
            offset_reg   <= '0;
            req_end_reg  <= '0;
            rem_reg      <= 16'd0;
            lacc_reg     <= 16'd0;
            iacc_reg     <= 32'd0;
            saved_reg    <= 32'd0;
            finished_reg <= 1'b0;
            failed_reg   <= 1'b0;
        end
        else if (fire)
        begin
            el_reg       <= el_next;
            sub_reg      <= sub_next;
            offset_reg   <= offset_next;
            req_end_reg  <= req_end_next;
            rem_reg      <= rem_next;
            lacc_reg     <= lacc_next;
            iacc_reg     <= iacc_next;
            saved_reg    <= saved_next;
            finished_reg <= finished_next;
            failed_reg   <= failed_next;
        end
    end

    always_comb
    begin
        push.val_valid             = fire && in_value;
        push.val_item.kind         = KIND_VALUE;
        push.val_item.value_byte   = data_byte;
        push.val_item.status       = ST_OK;
        push.val_item.device_error = 32'd0;
        push.val_item.end_of_run   = 1'b0;
        push.st_valid              = fire && last_byte;
        push.st_item.kind          = KIND_STATUS;
        push.st_item.value_byte    = 8'd0;
        push.st_item.status        = st_code;
        push.st_item.device_error  = (st_code == ST_DEV_ERR) ? p_saved : 32'd0;
        push.st_item.end_of_run    = 1'b1;
    end

    a_finished_done: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |-> (el_reg == EL_DONE))
        else $error("finished set while elements remain");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && last_byte) |=> (el_reg == EL_SEQ0 && sub_reg == SUB_TAG &&
                                 !failed_reg && !finished_reg && offset_reg == '0))
        else $error("parse state not cleared after final byte");

    a_value_needs_body: assert property (@(posedge clk) disable iff (!rst_n)
        push.val_valid |-> (rem_reg != 16'd0))
        else $error("value byte emitted with no content bytes pending");

endmodule
`default_nettype wire

// File: rtl/snmpve_out_fifo.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// snmpve_out_fifo
// Small result queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module snmpve_out_fifo (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire snmpve_pkg::push_t    push,
    output logic                      room,
    output logic                      result_valid,
    input  wire logic                 result_ready,
    output snmpve_pkg::result_t       result
);
    import snmpve_pkg::*;

    result_t              mem [OUTQ_DEPTH];
    logic [OUTQ_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [OUTQ_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [OUTQ_CW-1:0]   count_reg,  count_next;
    logic [OUTQ_AW-1:0]   st_addr;
    logic                 pop;
    logic [1:0]           n_push;

    assign pop          = result_valid && result_ready;
    assign n_push       = {1'b0, push.val_valid} + {1'b0, push.st_valid};
    assign st_addr      = push.val_valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
    assign wr_ptr_next  = wr_ptr_reg + OUTQ_AW'(n_push);
    assign rd_ptr_next  = rd_ptr_reg + OUTQ_AW'(pop);
    assign count_next   = count_reg + OUTQ_CW'(n_push) - OUTQ_CW'(pop);

    // A new request may bring two results, so keep space for both.
    assign room         = (count_reg <= OUTQ_CW'(OUTQ_DEPTH - 2));
    assign result_valid = (count_reg != '0);
    assign result       = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.val_valid)
            mem[wr_ptr_reg] <= push.val_item;
        if (push.st_valid)
            mem[st_addr] <= push.st_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        (n_push != 2'd0) |-> (count_reg + OUTQ_CW'(n_push) <= OUTQ_CW'(OUTQ_DEPTH)))
        else $error("result queue overflow");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= OUTQ_CW'(OUTQ_DEPTH))
        else $error("result queue count out of range");

endmodule
`default_nettype wire

// File: rtl/snmp_response_value_extract.sv
`timescale 1ns / 1ps
`default_nettype none
// Each result is written into the result queue when its request is taken.
// Throughput: one response byte per cycle, taken while the four-entry result
// queue has room for two; the final byte of a response adds a status item,
// so a final byte inside the value brings two results.
// Reset (rst_n low, asynchronous) clears the parse state and empties the queue.
// ----------------------------------------------------------------------------
// snmp_response_value_extract
// Streaming BER parser for SNMP GetResponse messages that emits the bytes of
// the value string and a status item at the end of each response.
// ----------------------------------------------------------------------------
module snmp_response_value_extract (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        item_valid,
    output logic             item_ready,
    input  wire logic [7:0]  data_byte,
    input  wire logic        last_byte,
    output logic             result_valid,
    input  wire logic        result_ready,
    output logic             kind,
    output logic [7:0]       value_byte,
    output logic [1:0]       status,
    output logic [31:0]      device_error,
    output logic             end_of_run
);
    import snmpve_pkg::*;

    push_t   push;
    result_t result;
    logic    room;
    logic    fire;

    assign item_ready = room;
    assign fire       = item_valid && item_ready;

    snmpve_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push)
    );

    snmpve_out_fifo u_out_fifo (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .room         (room),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    assign kind         = result.kind;
    assign value_byte   = result.value_byte;
    assign status       = result.status;
    assign device_error = result.device_error;
    assign end_of_run   = result.end_of_run;

endmodule
`default_nettype wire

// File: dv/snmp_response_value_extract_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// snmp_response_value_extract_tb
// Self-checking bench for the SNMP GetResponse value extractor. A short table
// of requests covers rejected lengths and a device error at its extreme value.
// Random responses follow: many are well formed with random content, and the
// rest are truncated, corrupted or plain noise. One last clean response closes
// the run. A parser model inside the bench predicts every value byte and
// status item.
// ----------------------------------------------------------------------------
module snmp_response_value_extract_tb;
    import snmpve_pkg::*;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 7;
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int RANDOM_ITEMS = 800;
    localparam int DRAIN_CYCLES = 10;
    localparam int HOLD_AT      = 600;
    localparam int HOLD_CYCLES  = 300;

    localparam int OFF_W = OFFSET_WIDTH;
    localparam logic [OFF_W-1:0] OFF_SAT = '1;

    localparam logic [7:0] TAG_SEQ      = 8'h30;
    localparam logic [7:0] TAG_INT      = 8'h02;
    localparam logic [7:0] TAG_OCTETS   = 8'h04;
    localparam logic [7:0] TAG_OID      = 8'h06;
    localparam logic [7:0] TAG_RESP_PDU = 8'ha2;
    localparam logic [7:0] LEN_INDEF    = 8'h80;
    localparam logic [7:0] LEN_RESERVED = 8'hff;
    localparam logic [7:0] LEN_LONG1    = 8'h81;
    localparam logic [7:0] LEN_LONG2    = 8'h82;
    localparam logic [7:0] LEN_LONG3    = 8'h83;
    localparam logic [7:0] LEN_LONG4    = 8'h84;

    localparam logic [3:0] EL_OUTER      = 4'd0;
    localparam logic [3:0] EL_VERSION    = 4'd1;
    localparam logic [3:0] EL_COMMUNITY  = 4'd2;
    localparam logic [3:0] EL_PDU        = 4'd3;
    localparam logic [3:0] EL_REQ_ID     = 4'd4;
    localparam logic [3:0] EL_ERR_STATUS = 4'd5;
    localparam logic [3:0] EL_ERR_INDEX  = 4'd6;
    localparam logic [3:0] EL_VARBINDS   = 4'd7;
    localparam logic [3:0] EL_VARBIND    = 4'd8;
    localparam logic [3:0] EL_OID        = 4'd9;
    localparam logic [3:0] EL_VALUE      = 4'd10;
    localparam logic [3:0] EL_DONE       = 4'd11;

    localparam logic [2:0] PH_TAG      = 3'd0;
    localparam logic [2:0] PH_LEN      = 3'd1;
    localparam logic [2:0] PH_LONG_LEN = 3'd2;
    localparam logic [2:0] PH_CONTENT  = 3'd3;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        logic [1:0]  status;
        logic [31:0] dev_err;
    } request_row_t;

    localparam int DIRECTED_COUNT = 25;

    // Rows with typed set carry their own status item; the others are checked
    // against the parser model.
    request_row_t directed_rows [DIRECTED_COUNT] = '{
        '{8'h00,        1'b1, 1'b1, ST_MALFORMED, 32'h0},
        '{TAG_SEQ,      1'b0, 1'b0, ST_OK,        32'h0},
        '{LEN_INDEF,    1'b1, 1'b1, ST_MALFORMED, 32'h0},
        '{TAG_SEQ,      1'b0, 1'b0, ST_OK,        32'h0},
        '{LEN_RESERVED, 1'b1, 1'b1, ST_MALFORMED, 32'h0},
        '{TAG_SEQ,      1'b0, 1'b0, ST_OK,        32'h0},
        '{LEN_LONG3,    1'b1, 1'b1, ST_MALFORMED, 32'h0},
        '{TAG_SEQ,      1'b0, 1'b0, ST_OK,        32'h0},
        '{8'h00,        1'b0, 1'b0, ST_OK,        32'h0},
        '{TAG_INT,      1'b0, 1'b0, ST_OK,        32'h0},
        '{8'h01,        1'b0, 1'b0, ST_OK,        32'h0},
        '{8'h00,        1'b0, 1'b0, ST_OK,        32'h0},
        '{TAG_OCTETS,   1'b0, 1'b0, ST_OK,        32'h0},
        '{8'h00,        1'b0, 1'b0, ST_OK,        32'h0},
        '{TAG_RESP_PDU, 1'b0, 1'b0, ST_OK,        32'h0},
        '{8'h00,        1'b0, 1'b0, ST_OK,        32'h0},
        '{TAG_INT,      1'b0, 1'b0, ST_OK,        32'h0},
        '{8'h01,        1'b0, 1'b0, ST_OK,        32'h0},
        '{8'h00,        1'b0, 1'b0, ST_OK,        32'h0},
        '{TAG_INT,      1'b0, 1'b0, ST_OK,        32'h0},
        '{8'h04,        1'b0, 1'b0, ST_OK,        32'h0},
        '{8'hff,        1'b0, 1'b0, ST_OK,        32'h0},
        '{8'hff,        1'b0, 1'b0, ST_OK,        32'h0},
        '{8'hff,        1'b0, 1'b0, ST_OK,        32'h0},
        '{8'hff,        1'b1, 1'b1, ST_DEV_ERR,   32'hffff_ffff}
    };

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        item_valid   = 1'b0;
    logic [7:0]  data_byte    = 8'h00;
    logic        last_byte    = 1'b0;
    logic        result_ready = 1'b0;
    logic        item_ready;
    logic        result_valid;
    logic        kind;
    logic [7:0]  value_byte;
    logic [1:0]  status;
    logic [31:0] device_error;
    logic        end_of_run;

    // Typed expectation that travels with the request on the input side.
    logic        req_typed  = 1'b0;
    logic [1:0]  req_status = ST_OK;
    logic [31:0] req_dev    = 32'h0;

    logic        tx_fast     = 1'b0;
    logic        clean_build = 1'b0;
    int          mismatch_count = 0;
    int          sent_items     = 0;
    logic [7:0]  frame [$];

    // Parser model state.
    logic [3:0]        p_elem;
    logic [2:0]        p_phase;
    logic [OFF_W-1:0]  p_offset;
    logic [OFF_W-1:0]  p_reach;
    logic [15:0]       p_left;
    logic [15:0]       p_len;
    logic [31:0]       p_int;
    logic [31:0]       p_dev;
    logic              p_done;
    logic              p_bad;
    result_t           expected_results [$];

    snmp_response_value_extract u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .kind         (kind),
        .value_byte   (value_byte),
        .status       (status),
        .device_error (device_error),
        .end_of_run   (end_of_run)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------
    function automatic void clear_parser();
        p_elem   = EL_OUTER;
        p_phase  = PH_TAG;
        p_offset = '0;
        p_reach  = '0;
        p_left   = '0;
        p_len    = '0;
        p_int    = '0;
        p_dev    = '0;
        p_done   = 1'b0;
        p_bad    = 1'b0;
    endfunction

    function automatic logic [OFF_W-1:0] offset_add(logic [OFF_W-1:0] a, logic [16:0] b);
        logic [OFF_W:0] s;
        s = a + b;
        return (s > OFF_SAT) ? OFF_SAT : s[OFF_W-1:0];
    endfunction

    function automatic logic [7:0] element_tag(logic [3:0] el);
        case (el)
            EL_OUTER, EL_VARBINDS, EL_VARBIND: return TAG_SEQ;
            EL_VERSION, EL_REQ_ID, EL_ERR_STATUS, EL_ERR_INDEX: return TAG_INT;
            EL_PDU: return TAG_RESP_PDU;
            EL_OID: return TAG_OID;
            default: return TAG_OCTETS;
        endcase
    endfunction

    function automatic logic element_is_int(logic [3:0] el);
        return el == EL_VERSION || el == EL_REQ_ID || el == EL_ERR_STATUS || el == EL_ERR_INDEX;
    endfunction

    function automatic void step_element();
        p_elem  = p_elem + 4'd1;
        p_phase = PH_TAG;
        if (p_elem >= EL_DONE) begin
            p_elem = EL_DONE;
            p_done = 1'b1;
        end
    endfunction

    function automatic void take_length(logic [15:0] dlen, logic [OFF_W-1:0] off_after);
        logic [OFF_W-1:0] need;
        need = offset_add(off_after, {1'b0, dlen});
        if (need > p_reach)
            p_reach = need;
        if (element_is_int(p_elem)) begin
            if (dlen != 16'd1 && dlen != 16'd2 && dlen != 16'd4) begin
                p_bad = 1'b1;
            end
            else begin
                p_int   = '0;
                p_left  = dlen;
                p_phase = PH_CONTENT;
            end
        end
        else if (p_elem == EL_COMMUNITY || p_elem == EL_OID || p_elem == EL_VALUE) begin
            if (dlen == 16'd0) begin
                step_element();
            end
            else begin
                p_left  = dlen;
                p_phase = PH_CONTENT;
            end
        end
        else begin
            // Constructed headers only declare a length; their content is parsed in line.
            step_element();
        end
    endfunction

    function automatic void parse_octet(logic [7:0] b, logic [OFF_W-1:0] off_after);
        if (p_bad || p_done || p_elem >= EL_DONE)
            return;
        case (p_phase)
            PH_TAG: begin
                if (b != element_tag(p_elem))
                    p_bad = 1'b1;
                else
                    p_phase = PH_LEN;
            end
            PH_LEN: begin
                if (b == LEN_INDEF || b == LEN_RESERVED) begin
                    p_bad = 1'b1;
                end
                else if (!b[7]) begin
                    take_length({8'h00, b}, off_after);
                end
                else if (b[6:0] > 7'd2) begin
                    p_bad = 1'b1;
                end
                else begin
                    p_left  = {9'd0, b[6:0]};
                    p_len   = '0;
                    p_phase = PH_LONG_LEN;
                end
            end
            PH_LONG_LEN: begin
                p_len  = {p_len[7:0], b};
                p_left = p_left - 16'd1;
                if (p_left == 16'd0)
                    take_length(p_len, off_after);
            end
            PH_CONTENT: begin
                p_left = p_left - 16'd1;
                if (element_is_int(p_elem)) begin
                    p_int = {p_int[23:0], b};
                    if (p_left == 16'd0) begin
                        if (p_elem == EL_VERSION && p_int != 32'd0) begin
                            p_bad = 1'b1;
                        end
                        else if (p_elem == EL_ERR_STATUS && p_int != 32'd0) begin
                            // A device error ends the parse; the rest is ignored.
                            p_dev   = p_int;
                            p_elem  = EL_DONE;
                            p_phase = PH_TAG;
                            p_done  = 1'b1;
                        end
                        else begin
                            step_element();
                        end
                    end
                end
                else if (p_left == 16'd0) begin
                    step_element();
                end
            end
            default: p_bad = 1'b1;
        endcase
    endfunction

    function automatic void predict_request(logic [7:0] b, logic last, logic typed,
                                            logic [1:0] t_status, logic [31:0] t_dev);
        logic [OFF_W-1:0] off_after;
        logic             in_value;
        result_t          r;
        off_after = offset_add(p_offset, 17'd1);
        in_value  = !p_bad && !p_done && p_elem == EL_VALUE && p_phase == PH_CONTENT;
        parse_octet(b, off_after);
        p_offset = off_after;
        if (in_value) begin
            r.kind         = KIND_VALUE;
            r.value_byte   = b;
            r.status       = ST_OK;
            r.device_error = '0;
            r.end_of_run   = 1'b0;
            expected_results.push_back(r);
        end
        if (last) begin
            r.kind         = KIND_STATUS;
            r.value_byte   = '0;
            r.device_error = '0;
            r.end_of_run   = 1'b1;
            if (p_bad || p_reach > p_offset || !p_done) begin
                r.status = ST_MALFORMED;
            end
            else if (p_dev != 32'd0) begin
                r.status       = ST_DEV_ERR;
                r.device_error = p_dev;
            end
            else begin
                r.status = ST_OK;
            end
            if (typed) begin
                r.status       = t_status;
                r.device_error = t_dev;
            end
            expected_results.push_back(r);
            clear_parser();
        end
    endfunction

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Requests are predicted and results checked at the same rising edge.
    always @(posedge clk) begin
        result_t got;
        result_t want;
        if (rst_n) begin
            if (item_valid && item_ready) begin
                sent_items++;
                predict_request(data_byte, last_byte, req_typed, req_status, req_dev);
            end
            if (result_valid && result_ready) begin
                got.kind         = kind;
                got.value_byte   = value_byte;
                got.status       = status;
                got.device_error = device_error;
                got.end_of_run   = end_of_run;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual kind %0d value %0h status %0d device_error %0h eor %0d",
                             $time, got.kind, got.value_byte, got.status,
                             got.device_error, got.end_of_run);
                    mismatch_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(got.kind));
                    check_field("value_byte", 32'(want.value_byte), 32'(got.value_byte));
                    check_field("status", 32'(want.status), 32'(got.status));
                    check_field("device_error", want.device_error, got.device_error);
                    check_field("end_of_run", 32'(want.end_of_run), 32'(got.end_of_run));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Response builder
    // ------------------------------------------------------------------
    function automatic void put_len(int unsigned n);
        int unsigned r = $urandom_range(0, 9);
        if (n < 128 && r < 6) begin
            frame.push_back(n[7:0]);
        end
        else if (n < 256 && r < 8) begin
            frame.push_back(LEN_LONG1);
            frame.push_back(n[7:0]);
        end
        else begin
            frame.push_back(LEN_LONG2);
            frame.push_back(n[15:8]);
            frame.push_back(n[7:0]);
        end
    endfunction

    function automatic void put_int(int unsigned len, logic [31:0] v);
        frame.push_back(TAG_INT);
        put_len(len);
        for (int i = int'(len) - 1; i >= 0; i--) begin
            if (i < 4)
                frame.push_back(v[8*i +: 8]);
            else
                frame.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    function automatic void put_blob(logic [7:0] tag, int unsigned n);
        frame.push_back(tag);
        put_len(n);
        repeat (n) frame.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic int unsigned seq_len();
        int unsigned r = $urandom_range(0, 99);
        if (clean_build)
            return 0;
        if (r < 88)
            return $urandom_range(0, 12);
        return $urandom_range(13, 65535);
    endfunction

    function automatic int unsigned int_len();
        int unsigned pick = $urandom_range(0, 2);
        if (!clean_build && $urandom_range(0, 29) == 0) begin
            case (pick)
                0: return 0;
                1: return 3;
                default: return 5;
            endcase
        end
        case (pick)
            0: return 1;
            1: return 2;
            default: return 4;
        endcase
    endfunction

    function automatic void build_response();
        int unsigned vlen;
        int unsigned r;
        int unsigned keep;
        int unsigned idx;
        frame.delete();
        if (!clean_build && $urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(1, 6)) frame.push_back(8'($urandom_range(0, 255)));
            return;
        end
        frame.push_back(TAG_SEQ);
        put_len(seq_len());
        put_int(int_len(), (!clean_build && $urandom_range(0, 24) == 0) ? $urandom : 32'd0);
        put_blob(TAG_OCTETS, $urandom_range(0, 10));
        frame.push_back(TAG_RESP_PDU);
        put_len(seq_len());
        put_int(int_len(), $urandom);
        put_int(int_len(), (!clean_build && $urandom_range(0, 7) == 0) ? $urandom : 32'd0);
        put_int(int_len(), $urandom);
        frame.push_back(TAG_SEQ);
        put_len(seq_len());
        frame.push_back(TAG_SEQ);
        put_len(seq_len());
        put_blob(TAG_OID, $urandom_range(0, 8));
        vlen = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 300) : $urandom_range(0, 16);
        put_blob(TAG_OCTETS, vlen);
        if (clean_build)
            return;
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 4)) frame.push_back(8'($urandom_range(0, 255)));
        r   = $urandom_range(0, 99);
        idx = $urandom_range(0, frame.size() - 1);
        if (r < 8) begin
            keep = $urandom_range(1, frame.size() - 1);
            while (frame.size() > keep)
                void'(frame.pop_back());
        end
        else if (r < 16) begin
            frame[idx] = 8'($urandom_range(0, 255));
        end
        else if (r < 22) begin
            case ($urandom_range(0, 3))
                0: frame[idx] = LEN_INDEF;
                1: frame[idx] = LEN_RESERVED;
                2: frame[idx] = LEN_LONG3;
                default: frame[idx] = LEN_LONG4;
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------
    function automatic int tx_gap();
        int unsigned r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 25);
    endfunction

    function automatic int rx_gap();
        int unsigned r = $urandom_range(0, 99);
        if (r < 75)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Entered and left at a falling edge; valid drops for any gap, then rises for the byte.
    task automatic send_request(logic [7:0] b, logic last, logic typed,
                                logic [1:0] t_status, logic [31:0] t_dev);
        int gap;
        gap = tx_fast ? 0 : tx_gap();
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        item_valid <= 1'b1;
        data_byte  <= b;
        last_byte  <= last;
        req_typed  <= typed;
        req_status <= t_status;
        req_dev    <= t_dev;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_frame(logic close);
        foreach (frame[i])
            send_request(frame[i], close && i == frame.size() - 1, 1'b0, ST_OK, 32'h0);
    endtask

    // Result side: random stalls, free-running stretches, and one long hold-off
    // that lets the result queue fill and back up the request side.
    initial begin
        int   rx_cycle;
        int   rx_stall;
        logic rx_free;
        rx_cycle = 0;
        rx_stall = 0;
        rx_free  = 1'b0;
        forever begin
            @(negedge clk);
            rx_cycle++;
            if (rx_cycle % 150 == 0)
                rx_free = ($urandom_range(0, 2) == 0);
            if (rx_cycle == HOLD_AT)
                rx_stall = HOLD_CYCLES;
            if (rx_stall > 0) begin
                result_ready <= 1'b0;
                rx_stall--;
            end
            else begin
                result_ready <= 1'b1;
                if (!rx_free && $urandom_range(0, 3) == 0)
                    rx_stall = rx_gap();
            end
        end
    end

    initial begin
        int   cycle_count;
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("snmp_response_value_extract verification failed");
        $finish;
    end

    initial begin
        int         base;
        clear_parser();
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_request(directed_rows[i].data, directed_rows[i].last, directed_rows[i].typed,
                         directed_rows[i].status, directed_rows[i].dev_err);

        base = sent_items;
        while (sent_items - base < RANDOM_ITEMS) begin
            tx_fast = ($urandom_range(0, 4) == 0);
            build_response();
            send_frame(1'b1);
        end

        // A clean, well-formed response closes the run.
        clean_build = 1'b1;
        tx_fast     = 1'b1;
        build_response();
        clean_build = 1'b0;
        send_frame(1'b1);
        item_valid <= 1'b0;

        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("snmp_response_value_extract verification clean");
        else
            $display("snmp_response_value_extract verification failed");
        $finish;
    end

endmodule

// File: snmp_response_value_extract.f
rtl/snmpve_pkg.sv
rtl/snmpve_parser.sv
rtl/snmpve_out_fifo.sv
rtl/snmp_response_value_extract.sv
dv/snmp_response_value_extract_tb.sv
